>>> rtl/lmt_pkg.sv
package lmt_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SQ,
    ST_ROOT,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } state_t;

  localparam int DIFF_W   = 8;   // scaled difference lies in -100..100
  localparam int SUMSQ_W  = 15;  // up to 3 * 100^2
  localparam int ROOT_W   = 8;   // floor root up to 173
  localparam int VEL_W    = 26;
  localparam int NUM_W    = 31;  // |diff| * 4096 * speed, up to 100 * 4096 * 4095
  localparam int BOX_LIM  = 100;
  localparam int FRAC_SH  = 12;

endpackage

>>> rtl/linear_motion_trajectory.sv
// Channel   Handshake               Payload
// input     start / busy            in_opcode, in_start_*, in_end_*, in_speed, in_time_value
// result    out_valid (one cycle)   out_pos_x, out_pos_y, out_pos_z
//
// A query keeps busy high through ST_MUL, one multiply per axis through a
// single shared 32x32 multiplier, and then ST_OUT; out_valid is registered
// from ST_OUT, so the result is strobed once the block is back in ST_IDLE.
// A set request scales the differences by four until they fit the box, squares
// each axis in turn, runs a linear square-root search and then three 31-bit
// serial divisions, one per axis, none when the length is zero.
// Reset is synchronous and clears the trajectory to zero. Busy is high for
// the whole of an item; the receiver cannot stall, each result lasts one cycle.
module linear_motion_trajectory
  import lmt_pkg::*;
#(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_opcode,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_start_z,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic signed [COORD_BITS-1:0] in_end_z,
  input  logic [11:0]                  in_speed,
  input  logic signed [31:0]           in_time_value,
  output logic                         out_valid,
  output logic signed [31:0]           out_pos_x,
  output logic signed [31:0]           out_pos_y,
  output logic signed [31:0]           out_pos_z
);

  localparam int DW = COORD_BITS + 1;

  state_t state_r, state_nxt;

  // Trajectory state.
  logic signed [COORD_BITS-1:0] org_r [3];
  logic [31:0]                  org_t_r;
  logic signed [VEL_W-1:0]      vel_r [3];

  // Working registers.
  logic signed [DW-1:0]   d_r [3];
  logic [SUMSQ_W-1:0]     sum_r;
  logic [ROOT_W-1:0]      root_r;
  logic [1:0]             ax_r;
  logic [11:0]            spd_r;
  logic [31:0]            dt_r;
  logic [31:0]            pos_r [3];
  logic                   div_go_r;
  logic                   out_valid_r;

  // Scaling step: all in box, else divide each by 4 toward zero.
  logic in_box;
  always_comb begin
    in_box = 1'b1;
    for (int i = 0; i < 3; i++)
      if (d_r[i] > DW'(BOX_LIM) || d_r[i] < -DW'(BOX_LIM)) in_box = 1'b0;
  end

  function automatic logic signed [DW-1:0] quarter(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] a;
    a = v + ((v < 0) ? DW'(3) : DW'(0));
    return a >>> 2;
  endfunction

  // Shared multiplier: square term, or velocity times time step.
  logic signed [31:0] mul_a, mul_b;
  logic        [31:0] mul_p;
  logic signed [DIFF_W-1:0] d_small;
  always_comb begin
    d_small = d_r[ax_r][DIFF_W-1:0];
    if (state_r == ST_SQ) begin
      mul_a = 32'(d_small);
      mul_b = 32'(d_small);
    end else begin
      mul_a = 32'(vel_r[ax_r]);
      mul_b = dt_r;
    end
    mul_p = 32'(mul_a * mul_b);
  end

  // Divider operands: |d| * 4096 * speed, sign restored afterward.
  logic [NUM_W-1:0] dividend, quotient;
  logic             div_done;
  logic [DIFF_W-1:0] d_mag;
  assign d_mag    = d_small[DIFF_W-1] ? DIFF_W'(-d_small) : DIFF_W'(d_small);
  assign dividend = NUM_W'({d_mag, 12'b0} * spd_r);

  lmt_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go_r),
    .dividend (dividend),
    .divisor  (root_r),
    .done     (div_done),
    .quotient (quotient)
  );

  logic [SUMSQ_W:0] root_sq;
  logic [ROOT_W:0]  root_inc;
  assign root_inc = {1'b0, root_r} + 1'b1;
  assign root_sq  = (SUMSQ_W+1)'(root_inc * root_inc);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start) state_nxt = in_opcode ? ST_MUL : ST_SCALE;
      ST_SCALE: if (in_box) state_nxt = ST_SQ;
      ST_SQ:    if (ax_r == 2'd2) state_nxt = ST_ROOT;
      ST_ROOT:  if (root_sq > {1'b0, sum_r})
                  state_nxt = (root_r == '0) ? ST_IDLE : ST_DIV;
      ST_DIV:   if (div_done && ax_r == 2'd2) state_nxt = ST_IDLE;
      ST_MUL:   if (ax_r == 2'd2) state_nxt = ST_OUT;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Output decode.
  always_comb begin
    busy = (state_r != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
      ax_r        <= '0;
      org_t_r     <= '0;
      for (int i = 0; i < 3; i++) begin
        org_r[i] <= '0;
        vel_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_OUT);
      div_go_r    <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          ax_r <= '0;
          if (start) begin
            if (in_opcode) begin
              dt_r <= in_time_value - org_t_r;
            end else begin
              org_r[0] <= in_start_x;
              org_r[1] <= in_start_y;
              org_r[2] <= in_start_z;
              org_t_r  <= in_time_value;
              d_r[0]   <= DW'(in_end_x) - DW'(in_start_x);
              d_r[1]   <= DW'(in_end_y) - DW'(in_start_y);
              d_r[2]   <= DW'(in_end_z) - DW'(in_start_z);
              spd_r    <= in_speed;
              sum_r    <= '0;
            end
          end
        end
        ST_SCALE: begin
          if (!in_box)
            for (int i = 0; i < 3; i++) d_r[i] <= quarter(d_r[i]);
        end
        ST_SQ: begin
          sum_r <= sum_r + mul_p[SUMSQ_W-1:0];
          ax_r  <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
          root_r <= '0;
        end
        ST_ROOT: begin
          if (root_sq <= {1'b0, sum_r}) begin
            root_r <= root_inc[ROOT_W-1:0];
          end else if (root_r == '0) begin
            for (int i = 0; i < 3; i++) vel_r[i] <= '0;
          end else begin
            div_go_r <= 1'b1;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            vel_r[ax_r] <= d_small[DIFF_W-1] ? VEL_W'(-quotient) : VEL_W'(quotient);
            if (ax_r != 2'd2) begin
              ax_r     <= ax_r + 2'd1;
              div_go_r <= 1'b1;
            end
          end
        end
        ST_MUL: begin
          pos_r[ax_r] <= 32'($signed(mul_p) >>> FRAC_SH) + 32'(org_r[ax_r]);
          ax_r <= (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_pos_x = pos_r[0];
  assign out_pos_y = pos_r[1];
  assign out_pos_z = pos_r[2];

endmodule

>>> rtl/lmt_divider.sv
module lmt_divider
  import lmt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  logic [NUM_W-1:0]    dividend,
  input  logic [ROOT_W-1:0]   divisor,
  output logic                done,
  output logic [NUM_W-1:0]    quotient
);

  // Restoring divider, one quotient bit per cycle.
  logic [NUM_W-1:0]          q_r, q_nxt;
  logic [ROOT_W:0]           rem_r, rem_nxt;
  logic [$clog2(NUM_W+1)-1:0] cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [ROOT_W+1:0]         trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (go) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {rem_r, q_r[NUM_W-1]} - {2'b00, divisor};
      if (!trial[ROOT_W+1]) begin
        rem_nxt = trial[ROOT_W:0];
        q_nxt   = {q_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[ROOT_W-1:0], q_r[NUM_W-1]};
        q_nxt   = {q_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == ($clog2(NUM_W+1))'(NUM_W-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

>>> sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lmt_pkg::*;

  localparam int CW = 24;
  localparam int N_RANDOM = 1300;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int DRAIN_CYCLES = 200;

  // Request codes carried on in_opcode.
  localparam logic OP_SET   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic in_opcode;
  logic signed [CW-1:0] in_start_x, in_start_y, in_start_z;
  logic signed [CW-1:0] in_end_x, in_end_y, in_end_z;
  logic [11:0] in_speed;
  logic signed [31:0] in_time_value;
  logic out_valid;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;

  linear_motion_trajectory #(.COORD_BITS(CW)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode),
    .in_start_x(in_start_x), .in_start_y(in_start_y), .in_start_z(in_start_z),
    .in_end_x(in_end_x), .in_end_y(in_end_y), .in_end_z(in_end_z),
    .in_speed(in_speed), .in_time_value(in_time_value),
    .out_valid(out_valid),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z)
  );

  // One request as the sender sees it.
  typedef struct {
    logic                 op;
    logic signed [CW-1:0] sx, sy, sz, ex, ey, ez;
    logic [11:0]          spd;
    logic signed [31:0]   t;
  } motion_req_t;

  // One expected position.
  typedef struct {
    logic signed [31:0] px, py, pz;
  } position_t;

  // Trajectory state held by the predictor.
  logic signed [CW-1:0] traj_ox, traj_oy, traj_oz;
  logic [31:0]          traj_t0;
  longint               traj_vx, traj_vy, traj_vz;

  position_t pending_positions[$];
  int        error_count;
  int        cycle_count;
  int        result_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The cycle counter guards against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** linear_motion_trajectory: FAILED **");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s at result %0d: got %h expected %h",
             what, result_count, got, want);
    error_count++;
  endtask

  // Trajectory setup: shrink the difference vector by four until it fits
  // the box, take the floor root of its squared length and scale the
  // direction into a fixed-point velocity with 12 fraction bits.
  function automatic void set_trajectory(input motion_req_t r);
    longint dx, dy, dz, len, sum;
    dx = longint'(r.ex) - longint'(r.sx);
    dy = longint'(r.ey) - longint'(r.sy);
    dz = longint'(r.ez) - longint'(r.sz);
    traj_ox = r.sx;
    traj_oy = r.sy;
    traj_oz = r.sz;
    traj_t0 = r.t;
    while (dx > 100 || dx < -100 || dy > 100 || dy < -100 || dz > 100 || dz < -100) begin
      dx = dx / 4;
      dy = dy / 4;
      dz = dz / 4;
    end
    sum = dx * dx + dy * dy + dz * dz;
    len = 0;
    while ((len + 1) * (len + 1) <= sum) len++;
    if (len == 0) begin
      traj_vx = 0;
      traj_vy = 0;
      traj_vz = 0;
    end else begin
      traj_vx = dx * 4096 * longint'(r.spd) / len;
      traj_vy = dy * 4096 * longint'(r.spd) / len;
      traj_vz = dz * 4096 * longint'(r.spd) / len;
    end
  endfunction

  // Position along one axis: the product wraps at 32 bits, then an
  // arithmetic shift drops the fraction before the origin is added.
  function automatic logic [31:0] axis_position(input longint vel, input logic [31:0] dt,
                                                input logic signed [CW-1:0] org);
    logic signed [31:0] prod;
    prod = signed'(vel[31:0] * dt);
    return (prod >>> 12) + 32'(org);
  endfunction

  function automatic position_t query_position(input logic [31:0] t);
    position_t p;
    logic [31:0] dt;
    dt = t - traj_t0;
    p.px = axis_position(traj_vx, dt, traj_ox);
    p.py = axis_position(traj_vy, dt, traj_oy);
    p.pz = axis_position(traj_vz, dt, traj_oz);
    return p;
  endfunction

  // Results cannot be held off, so every strobe is checked at once.
  always @(posedge clk) begin
    position_t want;
    if (rst_n && out_valid) begin
      if (pending_positions.size() == 0) begin
        $display("unexpected result %h %h %h", out_pos_x, out_pos_y, out_pos_z);
        error_count++;
      end else begin
        want = pending_positions.pop_front();
        if (out_pos_x !== want.px) report_mismatch("pos_x", out_pos_x, want.px);
        if (out_pos_y !== want.py) report_mismatch("pos_y", out_pos_y, want.py);
        if (out_pos_z !== want.pz) report_mismatch("pos_z", out_pos_z, want.pz);
      end
      result_count++;
    end
  end

  // Drive one request at the falling edge and hold it until accepted.
  // Start drops at the falling edge after acceptance, while the block is busy.
  task automatic send_request(input motion_req_t r, input int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start         <= 1'b1;
    in_opcode     <= r.op;
    in_start_x    <= r.sx;
    in_start_y    <= r.sy;
    in_start_z    <= r.sz;
    in_end_x      <= r.ex;
    in_end_y      <= r.ey;
    in_end_z      <= r.ez;
    in_speed      <= r.spd;
    in_time_value <= r.t;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Accepted at this edge: predict now so the queue leads the result.
    if (r.op == OP_SET) set_trajectory(r);
    else pending_positions.push_back(query_position(r.t));
    @(negedge clk);
    start <= 1'b0;
  endtask

  function automatic motion_req_t make_req(input logic op,
      input int sx, input int sy, input int sz, input int ex, input int ey,
      input int ez, input int spd, input int t);
    motion_req_t r;
    r.op = op;
    r.sx = sx[CW-1:0]; r.sy = sy[CW-1:0]; r.sz = sz[CW-1:0];
    r.ex = ex[CW-1:0]; r.ey = ey[CW-1:0]; r.ez = ez[CW-1:0];
    r.spd = spd[11:0];
    r.t = t;
    return r;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
      1: return CW'($urandom_range(0, 400)) - CW'(200);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic motion_req_t rand_req(input logic op);
    motion_req_t r;
    r.op = op;
    r.sx = rand_coord(); r.sy = rand_coord(); r.sz = rand_coord();
    // Short segments next to the start exercise small lengths and zero.
    if ($urandom_range(0, 3) == 0) begin
      r.ex = r.sx + CW'($urandom_range(0, 6)) - CW'(3);
      r.ey = r.sy + CW'($urandom_range(0, 6)) - CW'(3);
      r.ez = r.sz + CW'($urandom_range(0, 6)) - CW'(3);
    end else begin
      r.ex = rand_coord(); r.ey = rand_coord(); r.ez = rand_coord();
    end
    r.spd = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 12'hfff : 12'h000)
                                       : 12'($urandom);
    r.t = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000)
                                     : $urandom;
    return r;
  endfunction

  function automatic int rand_gap();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 0;
      9: return $urandom_range(20, 120);
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  // Directed table: each row is a request and, for queries whose answer is
  // plain from the state, a typed-in expected position.
  motion_req_t directed_reqs[$];
  logic        directed_known[$];
  position_t   directed_want[$];

  task automatic add_row(input motion_req_t r, input logic known,
                         input int px, input int py, input int pz);
    position_t p;
    p.px = px; p.py = py; p.pz = pz;
    directed_reqs.push_back(r);
    directed_known.push_back(known);
    directed_want.push_back(p);
  endtask

  initial begin
    motion_req_t r;
    position_t   p;
    int          wait_cycles;
    error_count  = 0;
    cycle_count  = 0;
    result_count = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_SET;
    in_start_x = '0; in_start_y = '0; in_start_z = '0;
    in_end_x = '0; in_end_y = '0; in_end_z = '0;
    in_speed = '0;
    in_time_value = '0;
    traj_ox = '0; traj_oy = '0; traj_oz = '0;
    traj_t0 = '0;
    traj_vx = 0; traj_vy = 0; traj_vz = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A query before any setup sees the cleared state, with junk in the
    // fields that a query ignores.
    add_row(make_req(OP_QUERY, 5, -5, 7, 9, 9, 9, 4095, 12345), 1, 0, 0, 0);
    add_row(make_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 32'h80000000), 1, 0, 0, 0);
    // A zero-length segment gives zero velocity: position is the start.
    add_row(make_req(OP_SET, -8388608, 8388607, 17, -8388608, 8388607, 17, 4095, 100),
            0, 0, 0, 0);
    add_row(make_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 32'h7fffffff), 1, -8388608, 8388607, 17);
    // Unit step along x with unit speed: one count per time unit.
    add_row(make_req(OP_SET, 0, 0, 0, 1, 0, 0, 1, 0), 0, 0, 0, 0);
    add_row(make_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 8192), 1, 8192, 0, 0);
    add_row(make_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, -4096), 1, -4096, 0, 0);
    // Full-span diagonals with maximum speed, plus time wrap-around.
    add_row(make_req(OP_SET, -8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                     4095, 32'h7ffffff0), 0, 0, 0, 0);
    add_row(make_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 32'h80000010), 0, 0, 0, 0);
    add_row(make_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 32'h7fffffff), 0, 0, 0, 0);
    add_row(make_req(OP_SET, 8388607, 0, -8388608, -8388608, 0, 8388607, 4095, -1),
            0, 0, 0, 0);
    add_row(make_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 32'h80000000), 0, 0, 0, 0);
    add_row(make_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 1000), 0, 0, 0, 0);
    // Differences right at the box edge and just beyond it.
    add_row(make_req(OP_SET, 0, 0, 0, 100, -100, 100, 2048, 0), 0, 0, 0, 0);
    add_row(make_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 4096), 0, 0, 0, 0);
    add_row(make_req(OP_SET, 10, 20, 30, 111, 20, 30, 4095, 5), 0, 0, 0, 0);
    add_row(make_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 77777), 0, 0, 0, 0);
    // Speed zero with a long segment stays at the start.
    add_row(make_req(OP_SET, 3, 4, 5, 8000000, -8000000, 1, 0, 0), 0, 0, 0, 0);
    add_row(make_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 999999), 1, 3, 4, 5);
    // Differences of 3 and -2 vanish when a long axis forces a scaling step.
    add_row(make_req(OP_SET, 0, 0, 0, 200, 3, -2, 4095, 0), 0, 0, 0, 0);
    add_row(make_req(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 123456), 0, 0, 0, 0);

    foreach (directed_reqs[i]) begin
      send_request(directed_reqs[i], (i % 3 == 0) ? 0 : $urandom_range(1, 3));
      // A typed-in expectation must also agree with the predictor.
      if (directed_known[i]) begin
        p = pending_positions[$];
        if (p.px !== directed_want[i].px || p.py !== directed_want[i].py ||
            p.pz !== directed_want[i].pz) begin
          $display("directed row %0d: prediction disagrees with table", i);
          error_count++;
        end
      end
    end

    // Random part: a setup about one time in three, else a query, so that queries
    // see many trajectories, with runs of back-to-back requests too.
    for (int n = 0; n < N_RANDOM; n++) begin
      if ($urandom_range(0, 2) == 0) r = rand_req(OP_SET);
      else r = rand_req(OP_QUERY);
      send_request(r, (n % 200 < 30) ? 0 : rand_gap());
    end

    wait_cycles = 0;
    while (pending_positions.size() != 0 && wait_cycles < 10000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_positions.size() != 0) begin
      $display("%0d expected results never arrived", pending_positions.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("** linear_motion_trajectory: PASSED **");
    end else begin
      $display("** linear_motion_trajectory: FAILED **");
    end
    $finish;
  end

endmodule
